// ----- hdl/url_value_char_sanitizer_top_macros.svh -----
// Assertion helpers for the URL value sanitizer.
`ifndef URL_VALUE_CHAR_SANITIZER_TOP_MACROS_SVH
`define URL_VALUE_CHAR_SANITIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UVCS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UVCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/uvcs_pkg.sv -----
`default_nettype none

package uvcs_pkg;

   // Field and register widths
   localparam int CHAR_W = 16;
   localparam int FLAG_W = 11;

   // Whitespace hold buffer, capped so one item never releases more than 44 results
   localparam int SPACE_DEPTH = 32;
   localparam int SPACE_CAP = (SPACE_DEPTH < 43) ? SPACE_DEPTH : 43;
   localparam int SPACE_IDX_W = (SPACE_CAP > 1) ? $clog2(SPACE_CAP) : 1;
   localparam int SPACE_CNT_W = $clog2(SPACE_CAP + 1);

   // Script prefix hold
   localparam int PREFIX_LEN = 11;
   localparam int PREFIX_IDX_W = 4;
   localparam int PREFIX_CNT_W = 4;
   localparam int JS_LEN = 11;
   localparam int VB_LEN = 9;

   // Allow flag bits
   localparam int FLAG_SPACE = 0;
   localparam int FLAG_WS = 1;
   localparam int FLAG_DQUOTE = 2;
   localparam int FLAG_SQUOTE = 3;
   localparam int FLAG_LT = 4;
   localparam int FLAG_GT = 5;
   localparam int FLAG_AMP = 6;
   localparam int FLAG_PCT = 7;
   localparam int FLAG_NUL = 8;
   localparam int FLAG_HIGH = 9;
   localparam int FLAG_SCRIPT = 10;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NUL = 16'd0;
   localparam logic [CHAR_W-1:0] CH_TAB = 16'd9;
   localparam logic [CHAR_W-1:0] CH_LF = 16'd10;
   localparam logic [CHAR_W-1:0] CH_VT = 16'd11;
   localparam logic [CHAR_W-1:0] CH_FF = 16'd12;
   localparam logic [CHAR_W-1:0] CH_CR = 16'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 16'd32;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'd34;
   localparam logic [CHAR_W-1:0] CH_PCT = 16'd37;
   localparam logic [CHAR_W-1:0] CH_AMP = 16'd38;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'd39;
   localparam logic [CHAR_W-1:0] CH_LT = 16'd60;
   localparam logic [CHAR_W-1:0] CH_GT = 16'd62;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'd65;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 16'd90;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 16'd95;
   localparam logic [CHAR_W-1:0] CH_DEL = 16'd127;
   localparam logic [CHAR_W-1:0] CH_HIGH = 16'd128;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'd32;

   // Prefix match state: bit0 javascript: possible, bit1 vbscript: possible
   localparam logic [1:0] MATCH_BOTH = 2'b11;
   localparam logic [1:0] MATCH_NONE = 2'b00;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FEED,
      S_TAIL,
      S_END
   } state_type;

   // Whitespace classes that get held or dropped
   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // Fold ASCII upper case letters to lower case
   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_OFFSET : c;
   endfunction

   // "javascript:" by position
   function automatic logic [7:0] js_char(input logic [PREFIX_CNT_W-1:0] p);
      logic [7:0] r;
      case (p)
         4'd0: r = 8'h6A;
         4'd1: r = 8'h61;
         4'd2: r = 8'h76;
         4'd3: r = 8'h61;
         4'd4: r = 8'h73;
         4'd5: r = 8'h63;
         4'd6: r = 8'h72;
         4'd7: r = 8'h69;
         4'd8: r = 8'h70;
         4'd9: r = 8'h74;
         4'd10: r = 8'h3A;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // "vbscript:" by position
   function automatic logic [7:0] vb_char(input logic [PREFIX_CNT_W-1:0] p);
      logic [7:0] r;
      case (p)
         4'd0: r = 8'h76;
         4'd1: r = 8'h62;
         4'd2: r = 8'h73;
         4'd3: r = 8'h63;
         4'd4: r = 8'h72;
         4'd5: r = 8'h69;
         4'd6: r = 8'h70;
         4'd7: r = 8'h74;
         4'd8: r = 8'h3A;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/uvcs_char_unit.sv -----
`default_nettype none

// Classify one character against the allow flags and replace it if illegal.
module uvcs_char_unit (
   input  wire logic [uvcs_pkg::FLAG_W-1:0] flags,
   input  wire logic [uvcs_pkg::CHAR_W-1:0] ch,
   output logic [uvcs_pkg::CHAR_W-1:0]      clean_ch
);

   logic legal;

   // Judge legality per class
   always_comb begin
      case (ch)
         uvcs_pkg::CH_SPACE:  legal = flags[uvcs_pkg::FLAG_SPACE];
         uvcs_pkg::CH_TAB,
         uvcs_pkg::CH_LF,
         uvcs_pkg::CH_VT,
         uvcs_pkg::CH_FF,
         uvcs_pkg::CH_CR:     legal = flags[uvcs_pkg::FLAG_WS];
         uvcs_pkg::CH_DQUOTE: legal = flags[uvcs_pkg::FLAG_DQUOTE];
         uvcs_pkg::CH_SQUOTE: legal = flags[uvcs_pkg::FLAG_SQUOTE];
         uvcs_pkg::CH_LT:     legal = flags[uvcs_pkg::FLAG_LT];
         uvcs_pkg::CH_GT:     legal = flags[uvcs_pkg::FLAG_GT];
         uvcs_pkg::CH_AMP:    legal = flags[uvcs_pkg::FLAG_AMP];
         uvcs_pkg::CH_PCT:    legal = flags[uvcs_pkg::FLAG_PCT];
         uvcs_pkg::CH_NUL:    legal = flags[uvcs_pkg::FLAG_NUL];
         default: begin
            legal = ((ch >= uvcs_pkg::CH_SPACE) && (ch < uvcs_pkg::CH_DEL))
                  || ((ch >= uvcs_pkg::CH_HIGH) && flags[uvcs_pkg::FLAG_HIGH]);
         end
      endcase
   end

   // Replace with space when spaces are allowed, else underscore
   assign clean_ch = legal ? ch
                   : (flags[uvcs_pkg::FLAG_SPACE] ? uvcs_pkg::CH_SPACE : uvcs_pkg::CH_UNDERSCORE);

endmodule

`default_nettype wire

// ----- hdl/url_value_char_sanitizer_top.sv -----
// Sequence: after a req transfer the item is decoded, then passes through the shared character unit
//   (a released result, a held or dropped whitespace character), plus a release of held prefix
//   characters when a value ends, before the final result reaches the rsp output register.
// Throughput: one item at a time, the next accepted only once the last is done; rsp stalls hold it.
// Reset: synchronous, active high; clears allow flags and per-value state; hold buffers
//   need no clearing since only written entries are read.
`default_nettype none

`include "url_value_char_sanitizer_top_macros.svh"

module url_value_char_sanitizer_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_wr_en,
   input  wire logic [uvcs_pkg::FLAG_W-1:0]   csr_wr_data,  // allow_flags
   // input channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [uvcs_pkg::CHAR_W-1:0]   req_tdata,    // in_char
   input  wire logic                          req_tlast,    // in_last
   input  wire logic                          req_tuser,    // in_empty
   // result channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [uvcs_pkg::CHAR_W-1:0]        rsp_tdata,    // out_char
   output logic                               rsp_tlast,    // out_last
   output logic [1:0]                         rsp_tuser     // [0] out_has_char, [1] out_overflow
);

   localparam int CW = uvcs_pkg::CHAR_W;
   localparam int SCW = uvcs_pkg::SPACE_CNT_W;
   localparam int SIW = uvcs_pkg::SPACE_IDX_W;
   localparam int PCW = uvcs_pkg::PREFIX_CNT_W;
   localparam int PIW = uvcs_pkg::PREFIX_IDX_W;

   uvcs_pkg::state_type state_ff, state_in;

   logic [uvcs_pkg::FLAG_W-1:0] flags_ff;

   // accepted item
   logic [CW-1:0] c_ff;
   logic          last_ff;
   logic          empty_ff;

   // per-value state
   logic [CW-1:0]  prefix_hold_ff [uvcs_pkg::PREFIX_LEN];
   logic [PCW-1:0] prefix_count_ff, prefix_count_in;
   logic [1:0]     prefix_match_ff, prefix_match_in;
   logic           seen_ff, seen_in;
   logic [CW-1:0]  space_hold_ff [uvcs_pkg::SPACE_CAP];
   logic [SCW-1:0] space_count_ff, space_count_in;
   logic           discard_ff, discard_in;
   logic           overflow_ff, overflow_in;

   // sequencer indexes
   logic [PIW-1:0] pi_ff, pi_in;
   logic [SCW-1:0] si_ff, si_in;
   logic           src_prefix_ff, src_prefix_in;
   logic           char_pend_ff, char_pend_in;

   // one-deep pending result, so the final one can be marked
   logic          pend_v_ff, pend_v_in;
   logic [CW-1:0] pend_char_ff, pend_char_in;
   logic          pend_ovf_ff, pend_ovf_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_char_ff, rsp_char_in;
   logic          rsp_has_ff, rsp_has_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // write strobes for the hold buffers
   logic prefix_we;
   logic space_we;

   logic          accept;
   logic          end_flag;
   logic          out_free;
   logic          can_emit;
   logic          ws_block;
   logic [CW-1:0] feed_x;
   logic          feed_ws;
   logic [CW-1:0] space_rd;
   logic          space_pending;
   logic [CW-1:0] unit_ch;
   logic [CW-1:0] clean_ch;
   logic          emit_v;
   logic          advance;

   // prefix compare
   logic [CW-1:0] lc;
   logic          js_ok;
   logic          vb_ok;
   logic [1:0]    m_new;
   logic          script_hit;
   logic          prefix_active;

   assign accept = req_tvalid & req_tready;
   assign req_tready = (state_ff == uvcs_pkg::S_IDLE);
   assign end_flag = last_ff | empty_ff;
   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign can_emit = ~pend_v_ff | out_free;
   assign ws_block = (flags_ff[uvcs_pkg::FLAG_WS:uvcs_pkg::FLAG_SPACE] == 2'b00);

   // Select the character being fed and any held whitespace ahead of it
   assign feed_x = src_prefix_ff ? prefix_hold_ff[pi_ff] : c_ff;
   assign feed_ws = uvcs_pkg::is_ws(feed_x);
   assign space_rd = space_hold_ff[si_ff[SIW-1:0]];
   assign space_pending = (si_ff < space_count_ff);
   assign unit_ch = space_pending ? space_rd : feed_x;

   // Shared classify and replace unit
   uvcs_char_unit u_char_unit (
      .flags    (flags_ff),
      .ch       (unit_ch),
      .clean_ch (clean_ch)
   );

   // Step the script prefix match by one character
   assign lc = uvcs_pkg::fold_case(c_ff);
   assign js_ok = (prefix_count_ff < PCW'(uvcs_pkg::JS_LEN))
                && (lc == {8'd0, uvcs_pkg::js_char(prefix_count_ff)});
   assign vb_ok = (prefix_count_ff < PCW'(uvcs_pkg::VB_LEN))
                && (lc == {8'd0, uvcs_pkg::vb_char(prefix_count_ff)});
   assign m_new = {prefix_match_ff[1] & vb_ok, prefix_match_ff[0] & js_ok};
   assign script_hit = (m_new[0] && (prefix_count_ff == PCW'(uvcs_pkg::JS_LEN - 1)))
                     || (m_new[1] && (prefix_count_ff == PCW'(uvcs_pkg::VB_LEN - 1)));
   assign prefix_active = (prefix_match_ff != uvcs_pkg::MATCH_NONE)
                        && !flags_ff[uvcs_pkg::FLAG_SCRIPT];

   // Sequencer: next state, hold updates and result emission
   always_comb begin
      state_in = state_ff;
      prefix_count_in = prefix_count_ff;
      prefix_match_in = prefix_match_ff;
      seen_in = seen_ff;
      space_count_in = space_count_ff;
      discard_in = discard_ff;
      overflow_in = overflow_ff;
      pi_in = pi_ff;
      si_in = si_ff;
      src_prefix_in = src_prefix_ff;
      char_pend_in = char_pend_ff;
      pend_v_in = pend_v_ff;
      pend_char_in = pend_char_ff;
      pend_ovf_in = pend_ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_char_in = rsp_char_ff;
      rsp_has_in = rsp_has_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in = rsp_ovf_ff;
      prefix_we = 1'b0;
      space_we = 1'b0;
      emit_v = 1'b0;
      advance = 1'b0;

      case (state_ff)
         uvcs_pkg::S_IDLE: begin
            if (accept) begin
               state_in = uvcs_pkg::S_DECIDE;
            end
         end

         uvcs_pkg::S_DECIDE: begin
            if (discard_ff || empty_ff) begin
               state_in = uvcs_pkg::S_TAIL;
            end else if (prefix_active && script_hit) begin
               // script URL: drop the rest of the value
               discard_in = 1'b1;
               prefix_count_in = '0;
               prefix_match_in = uvcs_pkg::MATCH_NONE;
               state_in = uvcs_pkg::S_TAIL;
            end else if (prefix_active && (m_new != uvcs_pkg::MATCH_NONE)
                         && (prefix_count_ff < PCW'(uvcs_pkg::PREFIX_LEN))) begin
               // still a possible prefix: hold the character
               prefix_we = 1'b1;
               prefix_count_in = prefix_count_ff + PCW'(1);
               prefix_match_in = m_new;
               state_in = uvcs_pkg::S_TAIL;
            end else begin
               // release held prefix, then feed the character
               prefix_match_in = uvcs_pkg::MATCH_NONE;
               src_prefix_in = (prefix_count_ff != '0);
               pi_in = '0;
               char_pend_in = 1'b1;
               state_in = uvcs_pkg::S_FEED;
            end
         end

         uvcs_pkg::S_FEED: begin
            if (ws_block && feed_ws) begin
               // hold internal whitespace, drop leading whitespace
               if (seen_ff) begin
                  if (space_count_ff < SCW'(uvcs_pkg::SPACE_CAP)) begin
                     space_we = 1'b1;
                     space_count_in = space_count_ff + SCW'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               advance = 1'b1;
            end else if (space_pending) begin
               // release one held whitespace character
               if (can_emit) begin
                  emit_v = 1'b1;
                  si_in = si_ff + SCW'(1);
               end
            end else if (can_emit) begin
               emit_v = 1'b1;
               space_count_in = '0;
               si_in = '0;
               if (!feed_ws) begin
                  seen_in = 1'b1;
               end
               advance = 1'b1;
            end

            // Advance to the next fed character
            if (advance) begin
               if (src_prefix_ff) begin
                  if (PCW'(pi_ff) + PCW'(1) == prefix_count_ff) begin
                     prefix_count_in = '0;
                     src_prefix_in = 1'b0;
                     if (!char_pend_ff) begin
                        state_in = uvcs_pkg::S_TAIL;
                     end
                  end else begin
                     pi_in = pi_ff + PIW'(1);
                  end
               end else begin
                  char_pend_in = 1'b0;
                  state_in = uvcs_pkg::S_TAIL;
               end
            end
         end

         uvcs_pkg::S_TAIL: begin
            if (end_flag && !discard_ff && (prefix_count_ff != '0)) begin
               // end of value: release any held prefix
               prefix_match_in = uvcs_pkg::MATCH_NONE;
               src_prefix_in = 1'b1;
               pi_in = '0;
               char_pend_in = 1'b0;
               state_in = uvcs_pkg::S_FEED;
            end else begin
               state_in = uvcs_pkg::S_END;
            end
         end

         uvcs_pkg::S_END: begin
            if (pend_v_ff) begin
               // flush the pending result, marking it final at end of value
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in = pend_char_ff;
                  rsp_has_in = 1'b1;
                  rsp_last_in = end_flag;
                  rsp_ovf_in = pend_ovf_ff;
                  pend_v_in = 1'b0;
                  state_in = uvcs_pkg::S_IDLE;
               end
            end else if (end_flag) begin
               // nothing released: send an end-only marker
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in = '0;
                  rsp_has_in = 1'b0;
                  rsp_last_in = 1'b1;
                  rsp_ovf_in = overflow_ff;
                  state_in = uvcs_pkg::S_IDLE;
               end
            end else begin
               state_in = uvcs_pkg::S_IDLE;
            end

            // Reset per-value state once the value closes
            if (end_flag && (state_in == uvcs_pkg::S_IDLE)) begin
               prefix_count_in = '0;
               prefix_match_in = uvcs_pkg::MATCH_BOTH;
               seen_in = 1'b0;
               space_count_in = '0;
               discard_in = 1'b0;
               overflow_in = 1'b0;
            end
         end

         default: begin
            state_in = uvcs_pkg::S_IDLE;
         end
      endcase

      // Push an emitted result through the pending stage
      if (emit_v) begin
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_char_in = pend_char_ff;
            rsp_has_in = 1'b1;
            rsp_last_in = 1'b0;
            rsp_ovf_in = pend_ovf_ff;
         end
         pend_v_in = 1'b1;
         pend_char_in = clean_ch;
         pend_ovf_in = overflow_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uvcs_pkg::S_IDLE;
         flags_ff <= '0;
         prefix_count_ff <= '0;
         prefix_match_ff <= uvcs_pkg::MATCH_BOTH;
         seen_ff <= 1'b0;
         space_count_ff <= '0;
         discard_ff <= 1'b0;
         overflow_ff <= 1'b0;
         pi_ff <= '0;
         si_ff <= '0;
         src_prefix_ff <= 1'b0;
         char_pend_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            flags_ff <= csr_wr_data;
         end
         prefix_count_ff <= prefix_count_in;
         prefix_match_ff <= prefix_match_in;
         seen_ff <= seen_in;
         space_count_ff <= space_count_in;
         discard_ff <= discard_in;
         overflow_ff <= overflow_in;
         pi_ff <= pi_in;
         si_ff <= si_in;
         src_prefix_ff <= src_prefix_in;
         char_pend_ff <= char_pend_in;
         pend_v_ff <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and hold buffers
   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff <= req_tdata;
         last_ff <= req_tlast;
         empty_ff <= req_tuser;
      end
      if (prefix_we) begin
         prefix_hold_ff[prefix_count_ff[PIW-1:0]] <= c_ff;
      end
      if (space_we) begin
         space_hold_ff[space_count_ff[SIW-1:0]] <= feed_x;
      end
      pend_char_ff <= pend_char_in;
      pend_ovf_ff <= pend_ovf_in;
      rsp_char_ff <= rsp_char_in;
      rsp_has_ff <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_char_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = {rsp_ovf_ff, rsp_has_ff};

   `UVCS_ASSERT_IMPL(a_space_cap, 1'b1, space_count_ff <= SCW'(uvcs_pkg::SPACE_CAP), "whitespace hold count past capacity")
   `UVCS_ASSERT_IMPL(a_prefix_cap, 1'b1, prefix_count_ff <= PCW'(uvcs_pkg::PREFIX_LEN), "prefix hold count past length")
   `UVCS_ASSERT_IMPL(a_discard_quiet, discard_ff, !pend_v_ff, "result pending while value is discarded")
   `UVCS_ASSERT_IMPL(a_idle_flushed, state_ff == uvcs_pkg::S_IDLE, !pend_v_ff, "pending result left at idle")
   `UVCS_ASSERT_NEXT(a_accept_decide, accept, state_ff == uvcs_pkg::S_DECIDE, "accepted item not decoded next")

endmodule

`default_nettype wire
